/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by divisor_count_by_prime_trial.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/dcpt_pkg.sv */
// ----------------------------------------------------------------------------
// dcpt_pkg
// Shared constants and state encoding of the divisor counter.
// ----------------------------------------------------------------------------
package dcpt_pkg;

   localparam int SIEVE_LIMIT_DEF = 1024;
   localparam int INPUT_BITS_DEF  = 20;
   localparam int COUNT_W         = 8;
   // quotient bits retired per divider cycle
   localparam int DIV_STEP        = 4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_SV_READ,
      ST_SV_CHECK,
      ST_SV_MARK,
      ST_COLLECT,
      ST_IDLE,
      ST_FETCH,
      ST_DIV,
      ST_EVAL,
      ST_DONE
   } state_type;

endpackage

/* rtl/core/divisor_count_by_prime_trial.sv */
// Each prime tried passes through fetch, the 4-bit-per-cycle divider and evaluation; each repeat
//   division runs the divider again, and a final fetch ends the search if the table runs out.
//   An n above 1021^2 with no small factor tries all 172 primes; n = 0 skips the trials and
//   n = 1 ends after the first prime.
// One item at a time; the next beat is taken while a result waits in rsp.
// Reset: sieve clear, marking and table fill run before the first request is taken.
// ----------------------------------------------------------------------------
// divisor_count_by_prime_trial
// Counts the divisors of n by trial division over a sieve-built prime table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module divisor_count_by_prime_trial #(
   parameter int SIEVE_LIMIT = dcpt_pkg::SIEVE_LIMIT_DEF,
   parameter int INPUT_BITS  = dcpt_pkg::INPUT_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [INPUT_BITS-1:0]        req_n,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dcpt_pkg::COUNT_W-1:0] rsp_divisor_count
);

   localparam int IDX_W    = $clog2(SIEVE_LIMIT);
   localparam int PT_DEPTH = SIEVE_LIMIT / 2;
   localparam int PT_AW    = $clog2(PT_DEPTH);
   localparam int DIV_ITER = (INPUT_BITS + dcpt_pkg::DIV_STEP - 1) / dcpt_pkg::DIV_STEP;
   localparam int DIV_W    = DIV_ITER * dcpt_pkg::DIV_STEP;
   localparam int DCNT_W   = $clog2(DIV_ITER + 1);
   localparam int EXP_W    = $clog2(INPUT_BITS + 1);
   localparam int CW       = (INPUT_BITS > IDX_W) ? INPUT_BITS : IDX_W;
   localparam int OUT_W    = dcpt_pkg::COUNT_W;
   localparam int CNT_W    = OUT_W + 1;
   localparam int PW       = CNT_W + EXP_W;

   localparam logic [IDX_W+1:0] LIMIT_X  = (IDX_W+2)'(SIEVE_LIMIT);
   localparam logic [IDX_W:0]   LAST_IDX = (IDX_W+1)'(SIEVE_LIMIT - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = {1'b1, {OUT_W{1'b0}}};

   dcpt_pkg::state_type state_ff, state_in;

   logic [IDX_W:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]      odd_ff, odd_in;
   logic [IDX_W:0]        sq_ff, sq_in;
   logic [IDX_W:0]        mul_ff, mul_in;
   logic                  col_vld_ff, col_vld_in;
   logic [IDX_W-1:0]      col_idx_ff;
   logic [IDX_W-1:0]      pc_ff, pc_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic [INPUT_BITS-1:0] n_ff, n_in;
   logic [EXP_W-1:0]      exp_ff, exp_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [IDX_W:0]        rem_ff, rem_in;
   logic [DIV_W-1:0]      quo_ff, quo_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_data_ff, rsp_data_in;

   // sieve marks and prime table
   logic                  mark_mem [SIEVE_LIMIT];
   logic [IDX_W-1:0]      prime_mem [PT_DEPTH];
   logic                  mk_rd_ff;
   logic [IDX_W-1:0]      pt_rd_ff;
   logic                  mk_we, mk_wd, pt_we;
   logic [IDX_W-1:0]      mk_wa, mk_ra;

   logic [IDX_W:0]        step_rem;
   logic [DIV_W-1:0]      step_quo;
   logic [IDX_W+1:0]      sq_step, mul_step;
   logic                  sq_more, mul_more;
   logic [INPUT_BITS-1:0] quot;
   logic                  q_small, rem_zero, out_free;
   logic [EXP_W-1:0]      exp_inc;
   logic [PW-1:0]         prod;
   logic [CNT_W-1:0]      prod_sat;
   logic [CNT_W:0]        dbl;
   logic [OUT_W-1:0]      final_count;

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (mk_we) begin
         mark_mem[mk_wa] <= mk_wd;
      end
      mk_rd_ff <= mark_mem[mk_ra];
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         prime_mem[pc_ff[PT_AW-1:0]] <= col_idx_ff;
      end
      pt_rd_ff <= prime_mem[k_ff[PT_AW-1:0]];
   end

   // ---------------- trial divider, DIV_STEP bits a cycle ----------------
   always_comb begin
      step_rem = rem_ff;
      step_quo = quo_ff;
      for (int s = 0; s < dcpt_pkg::DIV_STEP; s++) begin
         step_rem = {step_rem[IDX_W-1:0], step_quo[DIV_W-1]};
         step_quo = {step_quo[DIV_W-2:0], 1'b0};
         if (step_rem >= {1'b0, pt_rd_ff}) begin
            step_rem    = step_rem - {1'b0, pt_rd_ff};
            step_quo[0] = 1'b1;
         end
      end
   end

   // ---------------- datapath helpers ----------------
   // (i+2)^2 = i^2 + 4i + 4
   assign sq_step  = (IDX_W+2)'(sq_ff) + {odd_ff, 2'b00} + (IDX_W+2)'(4);
   assign sq_more  = sq_step < LIMIT_X;
   assign mul_step = (IDX_W+2)'(mul_ff) + (IDX_W+2)'({odd_ff, 1'b0});
   assign mul_more = mul_step < LIMIT_X;

   assign quot     = quo_ff[INPUT_BITS-1:0];
   // quotient below p is the same test as p*p above n
   assign q_small  = CW'(quot) < CW'(pt_rd_ff);
   assign rem_zero = rem_ff == '0;
   assign exp_inc  = exp_ff + EXP_W'(1);
   assign prod     = PW'(cnt_ff) * PW'(exp_inc);
   assign prod_sat = (prod[PW-1:OUT_W] != '0) ? CNT_FULL : prod[CNT_W-1:0];
   assign dbl      = (n_ff != INPUT_BITS'(1)) ? {cnt_ff, 1'b0} : {1'b0, cnt_ff};
   assign final_count = (dbl[CNT_W:OUT_W] != '0) ? {OUT_W{1'b1}} : dbl[OUT_W-1:0];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // prime table fill follows in the cycle after the mark read
   assign pt_we = col_vld_ff && !mk_rd_ff;

   // ---------------- control ----------------
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      odd_in       = odd_ff;
      sq_in        = sq_ff;
      mul_in       = mul_ff;
      col_vld_in   = 1'b0;
      pc_in        = pt_we ? pc_ff + IDX_W'(1) : pc_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      exp_in       = exp_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mk_we        = 1'b0;
      mk_wa        = mul_ff[IDX_W-1:0];
      mk_wd        = 1'b1;
      mk_ra        = odd_ff;
      req_stall    = 1'b1;

      case (state_ff)
         dcpt_pkg::ST_CLEAR: begin
            // 0, 1 and even numbers from 4 start marked
            mk_we  = 1'b1;
            mk_wa  = idx_ff[IDX_W-1:0];
            mk_wd  = (idx_ff < (IDX_W+1)'(2)) ||
                     (!idx_ff[0] && idx_ff >= (IDX_W+1)'(4));
            idx_in = idx_ff + (IDX_W+1)'(1);
            if (idx_ff == LAST_IDX) begin
               odd_in   = IDX_W'(3);
               sq_in    = (IDX_W+1)'(9);
               state_in = dcpt_pkg::ST_SV_READ;
            end
         end
         dcpt_pkg::ST_SV_READ: begin
            mk_ra    = odd_ff;
            state_in = dcpt_pkg::ST_SV_CHECK;
         end
         dcpt_pkg::ST_SV_CHECK: begin
            if (!mk_rd_ff) begin
               mul_in   = sq_ff;
               state_in = dcpt_pkg::ST_SV_MARK;
            end else begin
               odd_in = odd_ff + IDX_W'(2);
               sq_in  = sq_step[IDX_W:0];
               if (sq_more) begin
                  state_in = dcpt_pkg::ST_SV_READ;
               end else begin
                  idx_in   = (IDX_W+1)'(2);
                  state_in = dcpt_pkg::ST_COLLECT;
               end
            end
         end
         dcpt_pkg::ST_SV_MARK: begin
            mk_we  = 1'b1;
            mk_wa  = mul_ff[IDX_W-1:0];
            mul_in = mul_step[IDX_W:0];
            if (!mul_more) begin
               odd_in = odd_ff + IDX_W'(2);
               sq_in  = sq_step[IDX_W:0];
               if (sq_more) begin
                  state_in = dcpt_pkg::ST_SV_READ;
               end else begin
                  idx_in   = (IDX_W+1)'(2);
                  state_in = dcpt_pkg::ST_COLLECT;
               end
            end
         end
         dcpt_pkg::ST_COLLECT: begin
            mk_ra      = idx_ff[IDX_W-1:0];
            col_vld_in = 1'b1;
            idx_in     = idx_ff + (IDX_W+1)'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = dcpt_pkg::ST_IDLE;
            end
         end
         dcpt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               n_in   = req_n;
               k_in   = '0;
               exp_in = '0;
               if (req_n == '0) begin
                  cnt_in   = '0;
                  state_in = dcpt_pkg::ST_DONE;
               end else begin
                  cnt_in   = CNT_W'(1);
                  state_in = dcpt_pkg::ST_FETCH;
               end
            end
         end
         dcpt_pkg::ST_FETCH: begin
            if (k_ff == pc_ff) begin
               state_in = dcpt_pkg::ST_DONE;
            end else begin
               rem_in   = '0;
               quo_in   = DIV_W'(n_ff);
               dcnt_in  = '0;
               state_in = dcpt_pkg::ST_DIV;
            end
         end
         dcpt_pkg::ST_DIV: begin
            rem_in  = step_rem;
            quo_in  = step_quo;
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(DIV_ITER - 1)) begin
               state_in = dcpt_pkg::ST_EVAL;
            end
         end
         dcpt_pkg::ST_EVAL: begin
            if (exp_ff == '0 && q_small) begin
               state_in = dcpt_pkg::ST_DONE;
            end else if (rem_zero) begin
               // divide out p once more
               n_in     = quot;
               exp_in   = exp_inc;
               rem_in   = '0;
               quo_in   = DIV_W'(quot);
               dcnt_in  = '0;
               state_in = dcpt_pkg::ST_DIV;
            end else begin
               if (exp_ff != '0) begin
                  cnt_in = prod_sat;
               end
               exp_in   = '0;
               k_in     = k_ff + IDX_W'(1);
               state_in = dcpt_pkg::ST_FETCH;
            end
         end
         dcpt_pkg::ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = final_count;
               state_in     = dcpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dcpt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcpt_pkg::ST_CLEAR;
         idx_ff       <= '0;
         odd_ff       <= '0;
         sq_ff        <= '0;
         mul_ff       <= '0;
         col_vld_ff   <= 1'b0;
         pc_ff        <= '0;
         k_ff         <= '0;
         exp_ff       <= '0;
         cnt_ff       <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         odd_ff       <= odd_in;
         sq_ff        <= sq_in;
         mul_ff       <= mul_in;
         col_vld_ff   <= col_vld_in;
         pc_ff        <= pc_in;
         k_ff         <= k_in;
         exp_ff       <= exp_in;
         cnt_ff       <= cnt_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_idx_ff  <= idx_ff[IDX_W-1:0];
      n_ff        <= n_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_divisor_count = rsp_data_ff;

   // ---------------- assertions ----------------
   `ASSERT_IMPLIES(a_rem_below_prime, clock, reset,
      state_ff == dcpt_pkg::ST_EVAL,
      !rem_ff[IDX_W] && (rem_ff[IDX_W-1:0] < pt_rd_ff),
      "trial remainder not below the prime")
   `ASSERT_IMPLIES(a_trial_in_table, clock, reset,
      state_ff == dcpt_pkg::ST_FETCH,
      k_ff <= pc_ff,
      "trial index ran past the prime table")
   `ASSERT_NEXT(a_result_waits, clock, reset,
      state_ff == dcpt_pkg::ST_DONE && rsp_valid_ff && rsp_stall,
      state_ff == dcpt_pkg::ST_DONE,
      "result left done while output register was full")

endmodule
